// ===== sv/rk4_pkg.sv =====
`timescale 1ns / 1ps

package rk4_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_X_START    = 2'd0;
    localparam logic [1:0] CFG_Y_START    = 2'd1;
    localparam logic [1:0] CFG_STEP_SIZE  = 2'd2;
    localparam logic [1:0] CFG_STEP_COUNT = 2'd3;

    // Reset values of the configuration registers
    localparam logic [31:0] X_START_RST    = 32'd0;
    localparam logic [31:0] Y_START_RST    = 32'd524288;
    localparam logic [31:0] STEP_SIZE_RST  = 32'd209715;
    localparam logic [5:0]  STEP_COUNT_RST = 6'd10;

    // Divide by six: 2^28 = 6 * DIV6_HI + 4, DIV3_RECIP = ceil(2^32 / 3)
    localparam logic signed [31:0] DIV6_HI    = 32'sd44739242;
    localparam logic signed [31:0] DIV3_RECIP = 32'sd1431655766;

    // Result of a clamp to the signed 32-bit range
    typedef struct packed {
        logic        hit;
        logic [31:0] val;
    } sat_res_t;

    function automatic sat_res_t sat32(input logic signed [63:0] v);
        sat_res_t r;
        if (v > 64'sd2147483647) begin
            r.hit = 1'b1;
            r.val = 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            r.hit = 1'b1;
            r.val = 32'h8000_0000;
        end else begin
            r.hit = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/rk4_ode_integrator.sv =====
`timescale 1ns / 1ps

// Channel   Handshake           Payload
// s_        s_valid / s_ready   s_start_req
// m_        m_valid / m_ready   m_point_index, m_x_value, m_y_value, m_saturated, m_last
// cfg_      cfg_wr_en           cfg_index, cfg_data
//
// A transfer with s_start_req high runs step_count RK4 steps, capped at MAX_STEPS, and emits
// one point more. The initial point is loaded from the push state; each step then runs on the
// single shared 32x32 multiplier (ten products per step, two of them for the reciprocal divide
// by six).
// s_ready is high only between runs; a stalled m_ready holds the sequencer at the next point.
// aresetn (synchronous) restores the configuration defaults and empties the output register.
module rk4_ode_integrator #(
    parameter int MAX_STEPS = 63,
    parameter int FRAC_BITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_start_req,
    // point channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_point_index,
    output logic signed [31:0] m_x_value,
    output logic signed [31:0] m_y_value,
    output logic        m_saturated,
    output logic        m_last
);
    import rk4_pkg::*;

    localparam int TW = 64 - FRAC_BITS;
    localparam int QW = 56;         // dividend width of the divide by six
    localparam int QH = QW / 2;

    localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] RND    = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] THREE  = 64'sd3 <<< FRAC_BITS;
    localparam logic [5:0]         NMAX   = 6'(MAX_STEPS);

    typedef enum logic [4:0] {
        ST_IDLE, ST_PUSH, ST_STEP_INIT, ST_SQ_MUL, ST_SQ_POST, ST_K_SUB, ST_K_ONE,
        ST_K_ACC, ST_K_ACC2, ST_K_MUL, ST_K_POST, ST_Y_ARG, ST_S_MUL, ST_DIV_PREP,
        ST_DIV_ABS, ST_DIV_HI, ST_DIV_LO, ST_DIV_FIX, ST_Y_UPD, ST_X_UPD
    } state_t;

    state_t state_reg;

    // configuration
    logic signed [31:0] x_start_reg, y_start_reg, step_size_reg;
    logic [5:0]         step_count_reg;

    // datapath registers
    logic signed [31:0] x_reg, y_reg, xm_reg, xe_reg, yt_reg, tmp_reg, kv_reg, s_reg;
    logic signed [39:0] xacc_reg;
    logic signed [63:0] prod_reg;
    logic signed [TW-1:0] t_reg;
    logic [QW-1:0]      dq_reg;
    logic [63:0]        qacc_reg;
    logic               neg_reg;
    logic [1:0]         stage_reg;
    logic [5:0]         k_reg, n_reg;
    logic               sat_reg;

    // output register
    logic               m_valid_reg;
    logic [5:0]         m_point_index_reg;
    logic signed [31:0] m_x_value_reg, m_y_value_reg;
    logic               m_saturated_reg, m_last_reg;

    logic signed [31:0] h, hh, xt, coef, mul_a, mul_b;
    logic signed [63:0] mul_prod, mpost_wide, t_sum, q64;
    logic signed [TW:0] t_ext, u_val;
    sat_res_t           mpost, ksub, kone, acc, yadd, xm_s, xe_s, qsat, xsat;
    logic [5:0]         n_start;
    logic               out_free, out_load;
    logic [31:0]        div_v;
    logic signed [31:0] div_hi, div_w;
    logic [63:0]        q_mag;

    assign h  = step_size_reg;
    assign hh = step_size_reg >>> 1;

    // argument of the square in f(x,y) for the current stage
    always_comb begin
        unique case (stage_reg)
            2'd0:    xt = x_reg;
            2'd3:    xt = xe_reg;
            default: xt = xm_reg;
        endcase
    end
    assign coef = (stage_reg == 2'd2) ? h : hh;

    // shared multiplier operand select
    always_comb begin
        unique case (state_reg)
            ST_SQ_MUL: begin
                mul_a = xt;
                mul_b = xt;
            end
            ST_K_MUL: begin
                mul_a = coef;
                mul_b = kv_reg;
            end
            ST_DIV_HI: begin
                mul_a = div_hi;
                mul_b = DIV6_HI;
            end
            ST_DIV_LO: begin
                mul_a = div_w;
                mul_b = DIV3_RECIP;
            end
            default: begin
                mul_a = h;
                mul_b = s_reg;
            end
        endcase
    end
    assign mul_prod = 64'(mul_a) * 64'(mul_b);

    // rounding, saturating adders
    assign mpost_wide = (prod_reg + RND) >>> FRAC_BITS;
    assign mpost = sat32(mpost_wide);
    assign ksub  = sat32(64'(yt_reg) - 64'(tmp_reg));
    assign kone  = sat32(64'(tmp_reg) + 64'(FX_ONE));
    assign acc   = sat32(64'(s_reg) + 64'(kv_reg));
    assign yadd  = sat32(64'(y_reg) + 64'(tmp_reg));
    assign xm_s  = sat32(64'(x_reg) + 64'(hh));
    assign xe_s  = sat32(64'(x_reg) + 64'(h));
    assign xsat  = sat32(64'(xacc_reg));

    // increment: floor((h*S + 3*2^F) / 2^F) then floor division by six
    assign t_sum = prod_reg + THREE;
    assign t_ext = {t_reg[TW-1], t_reg};
    assign u_val = t_reg[TW-1] ? ((TW+1)'(5) - t_ext) : t_ext;

    // u = hi*2^28 + lo = 6*(hi*DIV6_HI) + (4*hi + lo); the rest goes through 1/3 of its half
    assign div_hi = {4'd0, dq_reg[QW-1:QH]};
    assign div_v  = {2'b00, dq_reg[QW-1:QH], 2'b00} + {4'd0, dq_reg[QH-1:0]};
    assign div_w  = {1'b0, div_v[31:1]};
    assign q_mag  = qacc_reg + {32'd0, prod_reg[63:32]};
    assign q64    = neg_reg ? (64'd0 - q_mag) : q_mag;
    assign qsat   = sat32(q64);

    assign n_start  = (step_count_reg > NMAX) ? NMAX : step_count_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_PUSH) && out_free;

    // sequencer, datapath and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            x_start_reg    <= X_START_RST;
            y_start_reg    <= Y_START_RST;
            step_size_reg  <= STEP_SIZE_RST;
            step_count_reg <= STEP_COUNT_RST;
            sat_reg        <= 1'b0;
            k_reg          <= '0;
            n_reg          <= '0;
            stage_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_X_START:    x_start_reg    <= cfg_data;
                    CFG_Y_START:    y_start_reg    <= cfg_data;
                    CFG_STEP_SIZE:  step_size_reg  <= cfg_data;
                    CFG_STEP_COUNT: step_count_reg <= cfg_data[5:0];
                endcase
            end

            // output register: load a point or drain a transfer
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_start_req) begin
                        sat_reg   <= 1'b0;
                        n_reg     <= n_start;
                        k_reg     <= '0;
                        x_reg     <= x_start_reg;
                        xacc_reg  <= 40'(x_start_reg);
                        y_reg     <= y_start_reg;
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (out_free) begin
                        m_point_index_reg <= k_reg;
                        m_x_value_reg     <= x_reg;
                        m_y_value_reg     <= y_reg;
                        m_saturated_reg   <= sat_reg;
                        m_last_reg        <= (k_reg == n_reg);
                        state_reg         <= (k_reg == n_reg) ? ST_IDLE : ST_STEP_INIT;
                    end
                end
                ST_STEP_INIT: begin
                    xm_reg    <= xm_s.val;
                    xe_reg    <= xe_s.val;
                    sat_reg   <= sat_reg | xm_s.hit | xe_s.hit;
                    yt_reg    <= y_reg;
                    stage_reg <= 2'd0;
                    state_reg <= ST_SQ_MUL;
                end
                ST_SQ_MUL: begin
                    prod_reg  <= mul_prod;
                    state_reg <= ST_SQ_POST;
                end
                ST_SQ_POST: begin
                    tmp_reg   <= mpost.val;
                    sat_reg   <= sat_reg | mpost.hit;
                    state_reg <= ST_K_SUB;
                end
                ST_K_SUB: begin
                    tmp_reg   <= ksub.val;
                    sat_reg   <= sat_reg | ksub.hit;
                    state_reg <= ST_K_ONE;
                end
                ST_K_ONE: begin
                    kv_reg    <= kone.val;
                    sat_reg   <= sat_reg | kone.hit;
                    state_reg <= ST_K_ACC;
                end
                ST_K_ACC: begin
                    // k1 seeds the sum, k2 and k3 go in twice
                    if (stage_reg == 2'd0) begin
                        s_reg <= kv_reg;
                    end else begin
                        s_reg   <= acc.val;
                        sat_reg <= sat_reg | acc.hit;
                    end
                    priority if (stage_reg == 2'd1 || stage_reg == 2'd2) begin
                        state_reg <= ST_K_ACC2;
                    end else if (stage_reg == 2'd3) begin
                        state_reg <= ST_S_MUL;
                    end else begin
                        state_reg <= ST_K_MUL;
                    end
                end
                ST_K_ACC2: begin
                    s_reg     <= acc.val;
                    sat_reg   <= sat_reg | acc.hit;
                    state_reg <= ST_K_MUL;
                end
                ST_K_MUL: begin
                    prod_reg  <= mul_prod;
                    state_reg <= ST_K_POST;
                end
                ST_K_POST: begin
                    tmp_reg   <= mpost.val;
                    sat_reg   <= sat_reg | mpost.hit;
                    state_reg <= ST_Y_ARG;
                end
                ST_Y_ARG: begin
                    yt_reg    <= yadd.val;
                    sat_reg   <= sat_reg | yadd.hit;
                    stage_reg <= stage_reg + 2'd1;
                    state_reg <= ST_SQ_MUL;
                end
                ST_S_MUL: begin
                    prod_reg  <= mul_prod;
                    state_reg <= ST_DIV_PREP;
                end
                ST_DIV_PREP: begin
                    t_reg     <= t_sum[63:FRAC_BITS];
                    state_reg <= ST_DIV_ABS;
                end
                ST_DIV_ABS: begin
                    // negative dividends divide (5 - t) so the result floors
                    neg_reg   <= t_reg[TW-1];
                    dq_reg    <= QW'(u_val);
                    state_reg <= ST_DIV_HI;
                end
                ST_DIV_HI: begin
                    prod_reg  <= mul_prod;
                    state_reg <= ST_DIV_LO;
                end
                ST_DIV_LO: begin
                    qacc_reg  <= prod_reg;
                    prod_reg  <= mul_prod;
                    state_reg <= ST_DIV_FIX;
                end
                ST_DIV_FIX: begin
                    tmp_reg   <= qsat.val;
                    sat_reg   <= sat_reg | qsat.hit;
                    state_reg <= ST_Y_UPD;
                end
                ST_Y_UPD: begin
                    y_reg     <= yadd.val;
                    sat_reg   <= sat_reg | yadd.hit;
                    xacc_reg  <= xacc_reg + 40'(h);
                    k_reg     <= k_reg + 6'd1;
                    state_reg <= ST_X_UPD;
                end
                ST_X_UPD: begin
                    x_reg     <= xsat.val;
                    sat_reg   <= sat_reg | xsat.hit;
                    state_reg <= ST_PUSH;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_point_index = m_point_index_reg;
    assign m_x_value     = m_x_value_reg;
    assign m_y_value     = m_y_value_reg;
    assign m_saturated   = m_saturated_reg;
    assign m_last        = m_last_reg;

    // a run stays busy until its final point is loaded
    a_busy_until_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> !s_ready)
        else $error("request taken while a run is still in progress");

    // the flag restarts clear with each run
    a_first_point_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_point_index == 6'd0) |-> !m_saturated)
        else $error("initial point carries a saturation flag");

    // the final point never lies beyond the step limit
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_point_index <= NMAX))
        else $error("final point index beyond step limit");

endmodule
